/* hdl/tcid_pkg.sv */
// ----------------------------------------------------------------------------
// tcid_pkg: shared types and constants for the interferometric DOA block
// Item layouts, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package tcid_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 20;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int GUARD_BITS  = 60 - 2 * SAMPLE_BITS;

  localparam int ANGLE_W = 15;
  localparam int DIST_W  = 44;
  localparam int AMP_W   = 32;

  // Conjugate product parts.
  localparam int PROD_W = 2 * SAMPLE_BITS + 1;
  // Phase CORDIC and arcsine CORDIC datapath widths.
  localparam int C1_XW = 64;
  localparam int C1_ZW = 34;
  localparam int C2_XW = 34;
  localparam int C2_ZW = 34;
  // Phase as a fraction of pi, arcsine argument and its square.
  localparam int PHASE_W = 33;
  localparam int ARG_W   = PHASE_W + CFG_W + 1;
  localparam int ARGC_W  = 49;
  localparam int S_W     = 32;
  localparam int SQ_W    = 61;
  localparam int ROOT_W  = 31;
  localparam int ISQRT_W = 62;
  localparam int ISQRT_STEPS = 31;
  localparam int ANGP_W  = C2_ZW + 32;

  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [30:0] PI_Q29       = 31'd1686629713;
  localparam logic [CFG_W-1:0] ANGLE_SCALE_RST = 24'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_STEP  = 1'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] first_re;
    logic signed [SAMPLE_BITS-1:0] first_im;
    logic signed [SAMPLE_BITS-1:0] second_re;
    logic signed [SAMPLE_BITS-1:0] second_im;
    logic [INDEX_BITS-1:0]         sample_index;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] arrival_angle;
    logic [DIST_W-1:0]         target_distance;
    logic [AMP_W-1:0]          echo_amplitude;
    logic                      angle_saturated;
  } out_item_t;

  typedef struct packed {
    logic              zero;
    logic [DIST_W-1:0] rng;
  } c1_side_t;

  typedef struct packed {
    logic signed [S_W-1:0] s;
    logic [AMP_W-1:0]      amp;
    logic                  sat;
    logic [DIST_W-1:0]     rng;
  } rt_side_t;

  typedef struct packed {
    logic [AMP_W-1:0]  amp;
    logic              sat;
    logic [DIST_W-1:0] rng;
  } c2_side_t;

  // atan(2^-i) / pi in Q31.
  function automatic logic [31:0] atan_q31(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/tcid_cordic.sv */
// ----------------------------------------------------------------------------
// tcid_cordic: pipelined vectoring CORDIC
// One register stage for the half-plane fold, then one per rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcid_cordic import tcid_pkg::*; #(
  parameter int XW     = 64,
  parameter int ZW     = 34,
  parameter int STAGES = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [ZW-1:0] out_z,
  output logic [SIDE_W-1:0]    out_side
);

  localparam logic signed [ZW-1:0] QUARTER = {{(ZW-31){1'b0}}, 1'b1, 30'b0};

  logic                 vld_r  [0:STAGES];
  logic signed [XW-1:0] x_r    [0:STAGES];
  logic signed [XW-1:0] y_r    [0:STAGES];
  logic signed [ZW-1:0] z_r    [0:STAGES];
  logic [SIDE_W-1:0]    side_r [0:STAGES];

  logic signed [XW-1:0] x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;

  // Fold the left half-plane onto the right one.
  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    z0_nxt = '0;
    if (in_x[XW-1]) begin
      if (!in_y[XW-1]) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        z0_nxt = QUARTER;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        z0_nxt = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_rot
    logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt, a;

    assign a = $signed({{(ZW-32){1'b0}}, atan_q31(g)});

    always_comb begin
      xs = x_r[g] >>> g;
      ys = y_r[g] >>> g;
      if (!y_r[g][XW-1]) begin
        x_nxt = x_r[g] + ys;
        y_nxt = y_r[g] - xs;
        z_nxt = z_r[g] + a;
      end else begin
        x_nxt = x_r[g] - ys;
        y_nxt = y_r[g] + xs;
        z_nxt = z_r[g] - a;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g+1]    <= x_nxt;
        y_r[g+1]    <= y_nxt;
        z_r[g+1]    <= z_nxt;
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_valid = vld_r[STAGES];
  assign out_x     = x_r[STAGES];
  assign out_z     = z_r[STAGES];
  assign out_side  = side_r[STAGES];

endmodule

`default_nettype wire

/* hdl/tcid_isqrt.sv */
// ----------------------------------------------------------------------------
// tcid_isqrt: pipelined floor integer square root
// One result bit per register stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
`default_nettype none

module tcid_isqrt import tcid_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_v,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic               vld_r  [0:ISQRT_STEPS-1];
  logic [ISQRT_W-1:0] v_r    [0:ISQRT_STEPS-1];
  logic [ISQRT_W-1:0] r_r    [0:ISQRT_STEPS-1];
  logic [SIDE_W-1:0]  side_r [0:ISQRT_STEPS-1];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam logic [ISQRT_W-1:0] BIT = ISQRT_W'(1) << (2 * (ISQRT_STEPS - 1 - k));
    logic               vld_src;
    logic [ISQRT_W-1:0] v_src, r_src, sum, v_nxt, r_nxt;
    logic [SIDE_W-1:0]  side_src;

    if (k == 0) begin : g_first
      assign vld_src  = in_valid;
      assign v_src    = {{(ISQRT_W-SQ_W){1'b0}}, in_v};
      assign r_src    = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign v_src    = v_r[k-1];
      assign r_src    = r_r[k-1];
      assign side_src = side_r[k-1];
    end

    always_comb begin
      sum = r_src + BIT;
      if (v_src >= sum) begin
        v_nxt = v_src - sum;
        r_nxt = (r_src >> 1) + BIT;
      end else begin
        v_nxt = v_src;
        r_nxt = r_src >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= v_nxt;
        r_r[k]    <= r_nxt;
        side_r[k] <= side_src;
      end
    end
  end

  assign out_valid = vld_r[ISQRT_STEPS-1];
  assign out_root  = r_r[ISQRT_STEPS-1][ROOT_W-1:0];
  assign out_side  = side_r[ISQRT_STEPS-1];

endmodule

`default_nettype wire

/* hdl/two_channel_interferometric_doa_top.sv */
// ----------------------------------------------------------------------------
// two_channel_interferometric_doa_top: phase interferometer direction of arrival
// Conjugate product, phase CORDIC, arcsine via square root and CORDIC, range.
// ----------------------------------------------------------------------------
// Pipeline: stages 1 and 2, the phase CORDIC, stages A to F, the 31-stage square
// root, the arcsine CORDIC, stage G and the output register (stage H).
// Throughput: one item per cycle; every stage holds one item and all stages
// advance together whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears all valid bits, angle_scale to 1.0
// (Q16) and the range step to zero.
`default_nettype none

module two_channel_interferometric_doa_top import tcid_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Fixed-point constants of the datapath.
  localparam logic signed [C1_ZW-1:0]  HALF_Q31  = {{(C1_ZW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [ARG_W-1:0]  ONE_Q47   = {{(ARG_W-48){1'b0}}, 1'b1, 47'b0};
  localparam logic signed [ARGC_W-1:0] ONE_Q47C  = {{(ARGC_W-48){1'b0}}, 1'b1, 47'b0};
  localparam logic signed [ARGC_W-1:0] RND16     = {{(ARGC_W-17){1'b0}}, 1'b1, 16'b0};
  localparam logic signed [S_W-1:0]    ONE_Q30   = {{(S_W-31){1'b0}}, 1'b1, 30'b0};
  localparam logic [SQ_W-1:0]          ONE_Q60   = {1'b1, 60'b0};
  localparam logic signed [ANGP_W-1:0] RND46     = {{(ANGP_W-47){1'b0}}, 1'b1, 46'b0};
  localparam logic [63:0]              RND_LO    = 64'h0000_0000_8000_0000;
  localparam logic [63:0]              RND_AMP   = 64'(1) << (GUARD_BITS - 1);

  // Configuration registers. They must be written only while the pipeline is
  // empty (the block does not enforce this), so every stage may read them directly.
  logic [CFG_W-1:0] angle_scale_r, range_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_scale_r <= ANGLE_SCALE_RST;
      range_step_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_SCALE: angle_scale_r <= cfg_wdata;
        CFG_RANGE_STEP:  range_step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless a finished item waits in
  // the output register and the receiver stalls it.
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: the four partial products and the range product. The range
  // product of a 20-bit index and a 24-bit step always fits in 44 bits.
  logic                     v1_r;
  logic signed [2*SAMPLE_BITS-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic [DIST_W-1:0]        dist1_r;

  // Stage 2: conjugate product first * conj(second).
  logic                     v2_r;
  logic signed [PROD_W-1:0] re2_r, im2_r;
  logic                     zero2_r;
  logic [DIST_W-1:0]        dist2_r;
  logic signed [PROD_W-1:0] re_nxt, im_nxt;

  assign re_nxt = PROD_W'(p_rr_r) + PROD_W'(p_ii_r);
  assign im_nxt = PROD_W'(p_ir_r) - PROD_W'(p_ri_r);

  // Phase CORDIC.
  logic                     c1_valid;
  logic signed [C1_XW-1:0]  c1_x, c1_y, c1_mag;
  logic signed [C1_ZW-1:0]  c1_z;
  c1_side_t                 c1_in_side, c1_out_side;

  assign c1_x = $signed({{(C1_XW-PROD_W-GUARD_BITS){re2_r[PROD_W-1]}}, re2_r,
                         {GUARD_BITS{1'b0}}});
  assign c1_y = $signed({{(C1_XW-PROD_W-GUARD_BITS){im2_r[PROD_W-1]}}, im2_r,
                         {GUARD_BITS{1'b0}}});
  assign c1_in_side = '{zero: zero2_r, rng: dist2_r};

  tcid_cordic #(
    .XW(C1_XW), .ZW(C1_ZW), .STAGES(CORDIC_STAGES), .SIDE_W($bits(c1_side_t))
  ) u_phase_cordic (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(v2_r), .in_x(c1_x), .in_y(c1_y), .in_side(c1_in_side),
    .out_valid(c1_valid), .out_x(c1_mag), .out_z(c1_z), .out_side(c1_out_side)
  );

  // Stage A: clamp the phase to +-pi; a zero product has zero phase. Its
  // magnitude is zero too, which makes the amplitude path give zero.
  logic                      va_r;
  logic signed [PHASE_W-1:0] phase_a_r, phase_nxt;
  logic [63:0]               mag_a_r;
  logic [DIST_W-1:0]         dist_a_r;

  always_comb begin
    if (c1_out_side.zero) begin
      phase_nxt = '0;
    end else if (c1_z > HALF_Q31) begin
      phase_nxt = PHASE_W'(HALF_Q31);
    end else if (c1_z < -HALF_Q31) begin
      phase_nxt = PHASE_W'(-HALF_Q31);
    end else begin
      phase_nxt = PHASE_W'(c1_z);
    end
  end

  // Stage B: amplitude gain correction in two 32-bit halves, and the
  // phase times angle_scale product.
  logic                    vb_r;
  logic [63:0]             hi_b_r, lo_b_r;
  logic signed [ARG_W-1:0] arg_b_r;
  logic [DIST_W-1:0]       dist_b_r;

  // Stage C: combine the halves; clamp the argument to +-1 and flag it.
  logic                     vc_r;
  logic [63:0]              t_c_r;
  logic signed [ARGC_W-1:0] argc_c_r, argc_nxt;
  logic                     sat_c_r, sat_nxt;
  logic [DIST_W-1:0]        dist_c_r;

  always_comb begin
    sat_nxt  = 1'b0;
    argc_nxt = ARGC_W'(arg_b_r);
    if (arg_b_r > ONE_Q47) begin
      argc_nxt = ONE_Q47C;
      sat_nxt  = 1'b1;
    end else if (arg_b_r < -ONE_Q47) begin
      argc_nxt = -ONE_Q47C;
      sat_nxt  = 1'b1;
    end
  end

  // Stage D: remove the guard bits from the amplitude with saturation, and
  // round the argument from Q47 to Q30.
  logic                     vd_r;
  logic [AMP_W-1:0]         amp_d_r;
  logic signed [S_W-1:0]    s_d_r, s_nxt;
  logic                     sat_d_r;
  logic [DIST_W-1:0]        dist_d_r;
  logic [63:0]              ampw;
  logic signed [ARGC_W-1:0] argr;
  logic signed [ARGC_W-1:0] args;

  assign ampw = (t_c_r + RND_AMP) >> GUARD_BITS;
  assign argr = argc_c_r + RND16;
  assign args = argr >>> 17;

  always_comb begin
    s_nxt = args[S_W-1:0];
    if (s_nxt > ONE_Q30) begin
      s_nxt = ONE_Q30;
    end
  end

  // Stage E: square of the argument.
  logic                  ve_r;
  logic [SQ_W-1:0]       sq_e_r;
  logic signed [63:0]    sq_full;
  rt_side_t              side_e_r;

  assign sq_full = s_d_r * s_d_r;

  // Stage F: 1 - s^2 in Q60, the radicand of the cosine.
  logic                  vf_r;
  logic [SQ_W-1:0]       rad_f_r;
  rt_side_t              side_f_r;

  // Square root: cosine of the arrival angle in Q30.
  logic                  rt_valid;
  logic [ROOT_W-1:0]     rt_root;
  rt_side_t              rt_out_side;

  tcid_isqrt #(
    .SIDE_W($bits(rt_side_t))
  ) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(vf_r), .in_v(rad_f_r), .in_side(side_f_r),
    .out_valid(rt_valid), .out_root(rt_root), .out_side(rt_out_side)
  );

  // Arcsine CORDIC on (cos, sin).
  logic                    c2_valid;
  logic signed [C2_XW-1:0] c2_x, c2_y, c2_mag;
  logic signed [C2_ZW-1:0] c2_z;
  c2_side_t                c2_in_side, c2_out_side;

  assign c2_x = $signed({{(C2_XW-ROOT_W){1'b0}}, rt_root});
  assign c2_y = $signed({{(C2_XW-S_W){rt_out_side.s[S_W-1]}}, rt_out_side.s});
  assign c2_in_side = '{amp: rt_out_side.amp, sat: rt_out_side.sat,
                        rng: rt_out_side.rng};

  tcid_cordic #(
    .XW(C2_XW), .ZW(C2_ZW), .STAGES(CORDIC_STAGES), .SIDE_W($bits(c2_side_t))
  ) u_asin_cordic (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(rt_valid), .in_x(c2_x), .in_y(c2_y), .in_side(c2_in_side),
    .out_valid(c2_valid), .out_x(c2_mag), .out_z(c2_z), .out_side(c2_out_side)
  );

  // Stage G: fraction of pi to radians; stage H (output) rounds to Q13.
  logic                     vg_r;
  logic signed [ANGP_W-1:0] angp_g_r;
  c2_side_t                 side_g_r;
  logic signed [ANGP_W-1:0] angr;
  out_item_t                out_data_r;

  assign angr = angp_g_r + RND46;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      vg_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      va_r        <= c1_valid;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      vg_r        <= c2_valid;
      out_valid_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rr_r  <= in_data.first_re * in_data.second_re;
      p_ii_r  <= in_data.first_im * in_data.second_im;
      p_ir_r  <= in_data.first_im * in_data.second_re;
      p_ri_r  <= in_data.first_re * in_data.second_im;
      dist1_r <= in_data.sample_index * range_step_r;

      re2_r   <= re_nxt;
      im2_r   <= im_nxt;
      zero2_r <= (re_nxt == '0) && (im_nxt == '0);
      dist2_r <= dist1_r;

      phase_a_r <= phase_nxt;
      mag_a_r   <= c1_mag;
      dist_a_r  <= c1_out_side.rng;

      hi_b_r   <= 64'(mag_a_r[63:32]) * 64'(INV_GAIN_Q32);
      lo_b_r   <= 64'(mag_a_r[31:0]) * 64'(INV_GAIN_Q32);
      arg_b_r  <= phase_a_r * $signed({1'b0, angle_scale_r});
      dist_b_r <= dist_a_r;

      t_c_r    <= hi_b_r + ((lo_b_r + RND_LO) >> 32);
      argc_c_r <= argc_nxt;
      sat_c_r  <= sat_nxt;
      dist_c_r <= dist_b_r;

      amp_d_r  <= (ampw[63:32] != '0) ? '1 : ampw[31:0];
      s_d_r    <= s_nxt;
      sat_d_r  <= sat_c_r;
      dist_d_r <= dist_c_r;

      sq_e_r   <= sq_full[SQ_W-1:0];
      side_e_r <= '{s: s_d_r, amp: amp_d_r, sat: sat_d_r, rng: dist_d_r};

      rad_f_r  <= ONE_Q60 - sq_e_r;
      side_f_r <= side_e_r;

      angp_g_r <= c2_z * $signed({1'b0, PI_Q29});
      side_g_r <= c2_out_side;

      out_data_r.arrival_angle   <= angr[47+ANGLE_W-1:47];
      out_data_r.target_distance <= side_g_r.rng;
      out_data_r.echo_amplitude  <= side_g_r.amp;
      out_data_r.angle_saturated <= side_g_r.sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

  // While the input side is held off, the inner pipelines must not move.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(c1_valid) && $stable(rt_valid) && $stable(c2_valid)))
    else $error("pipeline moved during a stall");

  // A flagged argument is clamped to exactly plus or minus one.
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && sat_c_r) |-> (argc_c_r == ONE_Q47C || argc_c_r == -ONE_Q47C))
    else $error("saturation flag without clamped argument");

  // The arcsine CORDIC starts from a non-negative cosine, so its magnitude
  // can only grow and never turns negative.
  a_asin_mag_positive: assert property (@(posedge clk) disable iff (!rst_n)
    c2_valid |-> !c2_mag[C2_XW-1])
    else $error("arcsine CORDIC magnitude went negative");

endmodule

`default_nettype wire
